### src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// token kinds, token record and character class helpers for the tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  // token kinds
  localparam logic [4:0] KIND_SEMI    = 5'd0;
  localparam logic [4:0] KIND_LPAREN  = 5'd1;
  localparam logic [4:0] KIND_RPAREN  = 5'd2;
  localparam logic [4:0] KIND_LBRACE  = 5'd3;
  localparam logic [4:0] KIND_RBRACE  = 5'd4;
  localparam logic [4:0] KIND_LBRACK  = 5'd5;
  localparam logic [4:0] KIND_RBRACK  = 5'd6;
  localparam logic [4:0] KIND_PLUS    = 5'd7;
  localparam logic [4:0] KIND_MINUS   = 5'd8;
  localparam logic [4:0] KIND_STAR    = 5'd9;
  localparam logic [4:0] KIND_SLASH   = 5'd10;
  localparam logic [4:0] KIND_ASSIGN  = 5'd11;
  localparam logic [4:0] KIND_BANG    = 5'd12;
  localparam logic [4:0] KIND_PERCENT = 5'd13;
  localparam logic [4:0] KIND_AMP     = 5'd14;
  localparam logic [4:0] KIND_COLON   = 5'd15;
  localparam logic [4:0] KIND_LESS    = 5'd16;
  localparam logic [4:0] KIND_GREATER = 5'd17;
  localparam logic [4:0] KIND_COMMA   = 5'd18;
  localparam logic [4:0] KIND_DOT     = 5'd19;
  localparam logic [4:0] KIND_ARROW   = 5'd20;
  localparam logic [4:0] KIND_LE      = 5'd21;
  localparam logic [4:0] KIND_GE      = 5'd22;
  localparam logic [4:0] KIND_STRING  = 5'd23;
  localparam logic [4:0] KIND_IDENT   = 5'd24;
  localparam logic [4:0] KIND_INT     = 5'd25;
  localparam logic [4:0] KIND_EXIT    = 5'd26;
  localparam logic [4:0] KIND_FUNC    = 5'd27;
  localparam logic [4:0] KIND_RETURN  = 5'd28;
  localparam logic [4:0] KIND_BADSTR  = 5'd29;

  // characters with a role of their own
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // keyword candidate bits
  localparam int unsigned CAND_EXIT   = 0;
  localparam int unsigned CAND_FUNC   = 1;
  localparam int unsigned CAND_RETURN = 2;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // single-byte tokens: {hit, kind}
  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h3B:   r = {1'b1, KIND_SEMI};     // ;
      8'h28:   r = {1'b1, KIND_LPAREN};   // (
      8'h29:   r = {1'b1, KIND_RPAREN};   // )
      8'h7B:   r = {1'b1, KIND_LBRACE};   // {
      8'h7D:   r = {1'b1, KIND_RBRACE};   // }
      8'h5B:   r = {1'b1, KIND_LBRACK};   // [
      8'h5D:   r = {1'b1, KIND_RBRACK};   // ]
      8'h2B:   r = {1'b1, KIND_PLUS};     // +
      8'h2A:   r = {1'b1, KIND_STAR};     // *
      8'h2F:   r = {1'b1, KIND_SLASH};    // /
      8'h3D:   r = {1'b1, KIND_ASSIGN};   // =
      8'h21:   r = {1'b1, KIND_BANG};     // !
      8'h25:   r = {1'b1, KIND_PERCENT};  // %
      8'h26:   r = {1'b1, KIND_AMP};      // &
      8'h3A:   r = {1'b1, KIND_COLON};    // :
      8'h2C:   r = {1'b1, KIND_COMMA};    // ,
      8'h2E:   r = {1'b1, KIND_DOT};      // .
      default: r = {1'b0, KIND_SEMI};
    endcase
    return r;
  endfunction

  // keyword spelling, one character per index
  function automatic logic [7:0] kw_exit_char(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h65;  // e
      3'd1:    r = 8'h78;  // x
      3'd2:    r = 8'h69;  // i
      3'd3:    r = 8'h74;  // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_func_char(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h66;  // f
      3'd1:    r = 8'h75;  // u
      3'd2:    r = 8'h6E;  // n
      3'd3:    r = 8'h63;  // c
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_return_char(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h72;  // r
      3'd1:    r = 8'h65;  // e
      3'd2:    r = 8'h74;  // t
      3'd3:    r = 8'h75;  // u
      3'd4:    r = 8'h72;  // r
      3'd5:    r = 8'h6E;  // n
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### src/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// byte-at-a-time lexer: punctuation, two-char operators, identifiers with
// keywords, integers, strings and comments, with a small result queue
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | to block  | in_valid_i/in_stall_o | text_byte_i, end_of_text_i
//  out     | from block| out_valid_o/out_stall_i| token_kind_o, start_offset_o,
//          |           |                       | token_length_o, last_of_run_o
//
//  - one byte per cycle while in_stall_o is low; each is classified in the cycle
//    it is taken and its zero, one or two tokens go into a four-entry result queue
//  - tokens leave the queue at one per cycle while out_stall_i is low, so a
//    byte that closes two tokens puts them out one after the other
//  - in_stall_o rises when fewer than two queue entries are free
//  - out_stall_i only holds the queue head; input keeps flowing while room is left
//  - reset puts the scanner in idle at byte position zero with an empty queue
//
module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  localparam int unsigned PosW = POSITION_BITS;
  localparam int unsigned ExtW = (PosW > 16) ? PosW : 16;

  // scanner modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_MINUS   = 3'd5;
  localparam logic [2:0] MODE_LESS    = 3'd6;
  localparam logic [2:0] MODE_GREATER = 3'd7;

  localparam logic [2:0] CAND_ALL = 3'b111;

  // ------------------------------------------------------------------------
  // helpers
  // ------------------------------------------------------------------------
  function automatic logic [PosW-1:0] sat_inc(logic [PosW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // low 16 bits of a position, zero extended when positions are narrower
  function automatic logic [15:0] low16(logic [PosW-1:0] v);
    logic [ExtW-1:0] t;
    t = ExtW'(v);
    return t[15:0];
  endfunction

  // narrow keyword candidates by one more identifier character
  function automatic logic [2:0] cand_take(logic [PosW-1:0] cnt, logic [2:0] cand,
                                           logic [7:0] c);
    logic [2:0] hit;
    hit[stt_pkg::CAND_EXIT]   = (cnt < 4) && (stt_pkg::kw_exit_char(cnt[2:0]) == c);
    hit[stt_pkg::CAND_FUNC]   = (cnt < 4) && (stt_pkg::kw_func_char(cnt[2:0]) == c);
    hit[stt_pkg::CAND_RETURN] = (cnt < 6) && (stt_pkg::kw_return_char(cnt[2:0]) == c);
    return cand & hit;
  endfunction

  function automatic logic [4:0] word_kind(logic [PosW-1:0] cnt, logic [2:0] cand);
    logic [4:0] k;
    if (cnt == 4 && cand[stt_pkg::CAND_EXIT]) begin
      k = stt_pkg::KIND_EXIT;
    end else if (cnt == 4 && cand[stt_pkg::CAND_FUNC]) begin
      k = stt_pkg::KIND_FUNC;
    end else if (cnt == 6 && cand[stt_pkg::CAND_RETURN]) begin
      k = stt_pkg::KIND_RETURN;
    end else begin
      k = stt_pkg::KIND_IDENT;
    end
    return k;
  endfunction

  // ------------------------------------------------------------------------
  // scanner state
  // ------------------------------------------------------------------------
  logic [2:0]      mode_q, mode_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] tok_cnt_q, tok_cnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      cand_q, cand_d;

  // result queue
  stt_pkg::token_t fifo_q [4];
  logic [1:0]      rd_ptr_q, wr_ptr_q;
  logic [2:0]      fifo_cnt_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // room for the worst case of two tokens per byte
  assign in_stall_o = fifo_cnt_q > 3'd2;

  // ------------------------------------------------------------------------
  // one byte of scanning
  // token a closes the pending token; token b is a fresh single-byte token
  // or the flush at end of text (never both)
  // ------------------------------------------------------------------------
  stt_pkg::token_t tok_a, tok_b, slot0;
  logic            a_vld, b_vld, rescan;
  logic [5:0]      single;

  always_comb begin
    mode_d    = mode_q;
    start_d   = start_q;
    tok_cnt_d = tok_cnt_q;
    cand_d    = cand_q;
    pos_d     = pos_q;
    tok_a     = '0;
    tok_b     = '0;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    rescan    = 1'b0;
    single    = stt_pkg::single_kind(text_byte_i);

    unique case (mode_q)
      MODE_COMMENT: begin
        if (text_byte_i == stt_pkg::CH_NEWLINE) begin
          mode_d    = MODE_IDLE;
          tok_cnt_d = '0;
          cand_d    = CAND_ALL;
        end
      end
      MODE_STRING: begin
        if (text_byte_i == stt_pkg::CH_QUOTE) begin
          a_vld     = 1'b1;
          tok_a     = '{stt_pkg::KIND_STRING, low16(start_q), low16(tok_cnt_q), 1'b0};
          mode_d    = MODE_IDLE;
          tok_cnt_d = '0;
          cand_d    = CAND_ALL;
        end else begin
          tok_cnt_d = sat_inc(tok_cnt_q);
        end
      end
      MODE_IDENT: begin
        if (stt_pkg::is_alpha(text_byte_i) || stt_pkg::is_digit(text_byte_i)) begin
          cand_d    = cand_take(tok_cnt_q, cand_q, text_byte_i);
          tok_cnt_d = sat_inc(tok_cnt_q);
        end else begin
          a_vld  = 1'b1;
          tok_a  = '{word_kind(tok_cnt_q, cand_q), low16(start_q), low16(tok_cnt_q), 1'b0};
          rescan = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (stt_pkg::is_digit(text_byte_i)) begin
          tok_cnt_d = sat_inc(tok_cnt_q);
        end else begin
          a_vld  = 1'b1;
          tok_a  = '{stt_pkg::KIND_INT, low16(start_q), low16(tok_cnt_q), 1'b0};
          rescan = 1'b1;
        end
      end
      MODE_MINUS: begin
        a_vld = 1'b1;
        if (text_byte_i == stt_pkg::CH_GREATER) begin
          tok_a  = '{stt_pkg::KIND_ARROW, low16(start_q), 16'd2, 1'b0};
          mode_d = MODE_IDLE;
        end else begin
          tok_a  = '{stt_pkg::KIND_MINUS, low16(start_q), 16'd1, 1'b0};
          rescan = 1'b1;
        end
      end
      MODE_LESS: begin
        a_vld = 1'b1;
        if (text_byte_i == stt_pkg::CH_EQUAL) begin
          tok_a  = '{stt_pkg::KIND_LE, low16(start_q), 16'd2, 1'b0};
          mode_d = MODE_IDLE;
        end else begin
          tok_a  = '{stt_pkg::KIND_LESS, low16(start_q), 16'd1, 1'b0};
          rescan = 1'b1;
        end
      end
      MODE_GREATER: begin
        a_vld = 1'b1;
        if (text_byte_i == stt_pkg::CH_EQUAL) begin
          tok_a  = '{stt_pkg::KIND_GE, low16(start_q), 16'd2, 1'b0};
          mode_d = MODE_IDLE;
        end else begin
          tok_a  = '{stt_pkg::KIND_GREATER, low16(start_q), 16'd1, 1'b0};
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // byte starts something new from idle
    if (rescan) begin
      mode_d    = MODE_IDLE;
      start_d   = pos_q;
      tok_cnt_d = '0;
      cand_d    = CAND_ALL;
      if (text_byte_i == stt_pkg::CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (text_byte_i == stt_pkg::CH_QUOTE) begin
        mode_d  = MODE_STRING;
        start_d = sat_inc(pos_q);
      end else if (stt_pkg::is_alpha(text_byte_i)) begin
        mode_d    = MODE_IDENT;
        cand_d    = cand_take('0, CAND_ALL, text_byte_i);
        tok_cnt_d = PosW'(1);
      end else if (stt_pkg::is_digit(text_byte_i)) begin
        mode_d    = MODE_NUMBER;
        tok_cnt_d = PosW'(1);
      end else if (text_byte_i == stt_pkg::CH_MINUS) begin
        mode_d = MODE_MINUS;
      end else if (text_byte_i == stt_pkg::CH_LESS) begin
        mode_d = MODE_LESS;
      end else if (text_byte_i == stt_pkg::CH_GREATER) begin
        mode_d = MODE_GREATER;
      end else if (single[5]) begin
        b_vld = 1'b1;
        tok_b = '{single[4:0], low16(pos_q), 16'd1, 1'b0};
      end
    end

    // end of text: flush what is pending, then back to the reset state
    if (end_of_text_i) begin
      case (mode_d)
        MODE_IDENT: begin
          b_vld = 1'b1;
          tok_b = '{word_kind(tok_cnt_d, cand_d), low16(start_d), low16(tok_cnt_d), 1'b0};
        end
        MODE_NUMBER: begin
          b_vld = 1'b1;
          tok_b = '{stt_pkg::KIND_INT, low16(start_d), low16(tok_cnt_d), 1'b0};
        end
        MODE_STRING: begin
          b_vld = 1'b1;
          tok_b = '{stt_pkg::KIND_BADSTR, low16(start_d), low16(tok_cnt_d), 1'b0};
        end
        MODE_MINUS: begin
          b_vld = 1'b1;
          tok_b = '{stt_pkg::KIND_MINUS, low16(start_d), 16'd1, 1'b0};
        end
        MODE_LESS: begin
          b_vld = 1'b1;
          tok_b = '{stt_pkg::KIND_LESS, low16(start_d), 16'd1, 1'b0};
        end
        MODE_GREATER: begin
          b_vld = 1'b1;
          tok_b = '{stt_pkg::KIND_GREATER, low16(start_d), 16'd1, 1'b0};
        end
        default: begin
        end
      endcase
      mode_d    = MODE_IDLE;
      start_d   = '0;
      tok_cnt_d = '0;
      cand_d    = CAND_ALL;
      pos_d     = '0;
    end else begin
      pos_d = sat_inc(pos_q);
    end

    // the last token of this byte carries last_of_run
    tok_b.last = 1'b1;
    tok_a.last = !b_vld;
    slot0      = a_vld ? tok_a : tok_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      start_q   <= '0;
      tok_cnt_q <= '0;
      pos_q     <= '0;
      cand_q    <= CAND_ALL;
    end else if (in_acc) begin
      mode_q    <= mode_d;
      start_q   <= start_d;
      tok_cnt_q <= tok_cnt_d;
      pos_q     <= pos_d;
      cand_q    <= cand_d;
    end
  end

  // ------------------------------------------------------------------------
  // result queue: up to two writes per byte, one read per cycle
  // ------------------------------------------------------------------------
  logic [1:0] n_push;
  assign n_push = in_acc ? (2'(a_vld) + 2'(b_vld)) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= tok_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + n_push;
      rd_ptr_q   <= rd_ptr_q + 2'(out_acc);
      fifo_cnt_q <= fifo_cnt_q + 3'(n_push) - 3'(out_acc);
    end
  end

  assign out_valid_o    = fifo_cnt_q != 3'd0;
  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign start_offset_o = fifo_q[rd_ptr_q].start;
  assign token_length_o = fifo_q[rd_ptr_q].len;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  // queue never holds more than its four entries
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= 3'd4)
    else $error("result queue overflow");

  // a byte that ends the text leaves the scanner at position zero in idle
  a_text_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_text_i |=> pos_q == '0 && mode_q == MODE_IDLE)
    else $error("scanner not reset after end of text");

  // idle scanner holds no partial token
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> tok_cnt_q == '0 && cand_q == CAND_ALL)
    else $error("idle scanner with leftover token state");

  // a token that is not the last of its byte always has its partner queued
  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_run_o |-> fifo_cnt_q >= 3'd2)
    else $error("second token of a byte missing");
`endif

endmodule

### dv/token_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// token_scoreboard_pkg
// token predictor and in-order checker for the source text tokenizer bench
// ----------------------------------------------------------------------------
package token_scoreboard_pkg;

  import stt_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_COMMENT,
    SCAN_MINUS,
    SCAN_LESS,
    SCAN_GREATER
  } scan_mode_e;

  class token_scoreboard;
    scan_mode_e  mode;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] byte_pos;
    logic [2:0]  kw_alive;
    string       keywords[3];
    token_t      byte_tokens[$];
    token_t      expected_tokens[$];
    int unsigned errors;

    function new();
      keywords[CAND_EXIT]   = "exit";
      keywords[CAND_FUNC]   = "func";
      keywords[CAND_RETURN] = "return";
      errors    = 0;
      tok_start = '0;
      byte_pos  = '0;
      clear_scan();
    endfunction

    static function logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    static function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    static function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    static function bit punct(logic [7:0] c, output logic [4:0] kind);
      punct = 1'b1;
      case (c)
        ";":     kind = KIND_SEMI;
        "(":     kind = KIND_LPAREN;
        ")":     kind = KIND_RPAREN;
        "{":     kind = KIND_LBRACE;
        "}":     kind = KIND_RBRACE;
        "[":     kind = KIND_LBRACK;
        "]":     kind = KIND_RBRACK;
        "+":     kind = KIND_PLUS;
        "*":     kind = KIND_STAR;
        "/":     kind = KIND_SLASH;
        "=":     kind = KIND_ASSIGN;
        "!":     kind = KIND_BANG;
        "%":     kind = KIND_PERCENT;
        "&":     kind = KIND_AMP;
        ":":     kind = KIND_COLON;
        ",":     kind = KIND_COMMA;
        ".":     kind = KIND_DOT;
        default: begin
          punct = 1'b0;
          kind  = KIND_SEMI;
        end
      endcase
    endfunction

    function void push(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
      token_t t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      byte_tokens.push_back(t);
    endfunction

    function void clear_scan();
      mode     = SCAN_IDLE;
      tok_len  = '0;
      kw_alive = 3'b111;
    endfunction

    // drop every keyword that no longer matches the spelling so far
    function void take_word_char(logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
        if (!(tok_len < keywords[k].len() && keywords[k][tok_len] == c)) kw_alive[k] = 1'b0;
      end
      tok_len = sat_inc(tok_len);
    endfunction

    function logic [4:0] word_kind();
      if (tok_len == 16'd4 && kw_alive[CAND_EXIT]) return KIND_EXIT;
      if (tok_len == 16'd4 && kw_alive[CAND_FUNC]) return KIND_FUNC;
      if (tok_len == 16'd6 && kw_alive[CAND_RETURN]) return KIND_RETURN;
      return KIND_IDENT;
    endfunction

    function void begin_token(logic [7:0] c, logic [15:0] pos);
      logic [4:0] kind;
      tok_start = pos;
      clear_scan();
      if (c == CH_HASH) mode = SCAN_COMMENT;
      else if (c == CH_QUOTE) begin
        mode      = SCAN_STRING;
        tok_start = sat_inc(pos);
      end else if (letter(c)) begin
        mode = SCAN_IDENT;
        take_word_char(c);
      end else if (digit(c)) begin
        mode    = SCAN_NUMBER;
        tok_len = 16'd1;
      end else if (c == CH_MINUS) mode = SCAN_MINUS;
      else if (c == CH_LESS) mode = SCAN_LESS;
      else if (c == CH_GREATER) mode = SCAN_GREATER;
      else if (punct(c, kind)) push(kind, pos, 16'd1);
    endfunction

    function void scan(logic [7:0] c, logic [15:0] pos);
      bit rescan;
      rescan = 1'b1;
      case (mode)
        SCAN_COMMENT: begin
          rescan = 1'b0;
          if (c == CH_NEWLINE) clear_scan();
        end
        SCAN_STRING: begin
          rescan = 1'b0;
          if (c == CH_QUOTE) begin
            push(KIND_STRING, tok_start, tok_len);
            clear_scan();
          end else tok_len = sat_inc(tok_len);
        end
        SCAN_IDENT: begin
          if (letter(c) || digit(c)) begin
            rescan = 1'b0;
            take_word_char(c);
          end else push(word_kind(), tok_start, tok_len);
        end
        SCAN_NUMBER: begin
          if (digit(c)) begin
            rescan  = 1'b0;
            tok_len = sat_inc(tok_len);
          end else push(KIND_INT, tok_start, tok_len);
        end
        SCAN_MINUS: begin
          if (c == CH_GREATER) begin
            rescan = 1'b0;
            push(KIND_ARROW, tok_start, 16'd2);
            clear_scan();
          end else push(KIND_MINUS, tok_start, 16'd1);
        end
        SCAN_LESS: begin
          if (c == CH_EQUAL) begin
            rescan = 1'b0;
            push(KIND_LE, tok_start, 16'd2);
            clear_scan();
          end else push(KIND_LESS, tok_start, 16'd1);
        end
        SCAN_GREATER: begin
          if (c == CH_EQUAL) begin
            rescan = 1'b0;
            push(KIND_GE, tok_start, 16'd2);
            clear_scan();
          end else push(KIND_GREATER, tok_start, 16'd1);
        end
        default: ;
      endcase
      if (rescan) begin_token(c, pos);
    endfunction

    function void flush();
      case (mode)
        SCAN_IDENT:   push(word_kind(), tok_start, tok_len);
        SCAN_NUMBER:  push(KIND_INT, tok_start, tok_len);
        SCAN_STRING:  push(KIND_BADSTR, tok_start, tok_len);
        SCAN_MINUS:   push(KIND_MINUS, tok_start, 16'd1);
        SCAN_LESS:    push(KIND_LESS, tok_start, 16'd1);
        SCAN_GREATER: push(KIND_GREATER, tok_start, 16'd1);
        default: ;
      endcase
    endfunction

    // one accepted text byte: queue the tokens it closes
    function void note_byte(logic [7:0] c, logic eot);
      token_t t;
      byte_tokens.delete();
      scan(c, byte_pos);
      if (eot) begin
        flush();
        clear_scan();
        tok_start = '0;
        byte_pos  = '0;
      end else byte_pos = sat_inc(byte_pos);
      foreach (byte_tokens[i]) begin
        t      = byte_tokens[i];
        t.last = (i == byte_tokens.size() - 1);
        expected_tokens.push_back(t);
      end
    endfunction

    function void check_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                              logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("token with nothing pending: kind %0d start %0d length %0d", kind, start, len);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (start !== want.start) begin
        $error("start_offset: expected %0d, got %0d", want.start, start);
        errors++;
      end
      if (len !== want.len) begin
        $error("token_length: expected %0d, got %0d", want.len, len);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

### dv/source_text_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// feeds short directed texts and random token-shaped texts through the
// tokenizer; every token is checked in order against a predictor, with
// bursty input, random output stalls and one long hold-off
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;
  import token_scoreboard_pkg::*;

  typedef logic [7:0] text_q_t[$];

  localparam int          HALF_PERIOD  = 2;
  localparam int          RESET_CYCLES = 9;
  // random part stops after about this many bytes
  localparam int unsigned RANDOM_BYTES = 1000;
  // receiver hold-off, long enough to fill the result queue and back up input
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned HOLD_AFTER   = 200;
  // cycles with no handshake at all before the run is declared hung
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam string WORD_CHARS  =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string PUNCT_CHARS = ";(){}[]+*/=!%&:,.";

  // keywords, near misses and the operator pairs with their broken forms
  string near_words[10] = '{"exit", "func", "return", "exit1", "funcs",
                            "retur", "returns", "ex", "f_unc", "Return"};
  string near_ops[10]   = '{"->", "<=", ">=", "-", "<", ">", "<>", "--", ">>", "-="};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  text_byte_i   = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [4:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  token_scoreboard sb;

  int unsigned inputs_taken = 0;  // updated with nonblocking so readers see edge values
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;

  // receiver stall pattern state
  int unsigned stall_span   = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  source_text_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // offer one byte and hold it until taken, then maybe open a gap between bursts
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      // some bursts are long stretches with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // the last byte of every text carries the end marker
  task automatic send_text(input text_q_t txt);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  function automatic text_q_t bytes_of(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // mostly well-formed lexemes, packed with and without separators, plus noise;
  // now and then the text is cut short so it ends inside a token
  function automatic text_q_t random_text();
    text_q_t     t;
    string       s;
    int unsigned n;
    logic [7:0]  c;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 11))
        0: begin
          s = near_words[$urandom_range(0, $size(near_words) - 1)];
          for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        end
        1: begin
          t.push_back(WORD_CHARS[$urandom_range(0, 52)]);
          repeat ($urandom_range(0, 6)) t.push_back(WORD_CHARS[$urandom_range(0, 62)]);
        end
        2: repeat ($urandom_range(1, 5)) t.push_back(8'($urandom_range(8'h30, 8'h39)));
        3: begin
          // string, possibly empty, possibly spanning lines, possibly unclosed
          t.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            c = ($urandom_range(0, 5) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255));
            t.push_back((c == CH_QUOTE) ? CH_UNDER : c);
          end
          if ($urandom_range(0, 9) != 0) t.push_back(CH_QUOTE);
        end
        4: begin
          t.push_back(CH_HASH);
          repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            t.push_back((c == CH_NEWLINE) ? CH_HASH : c);
          end
          if ($urandom_range(0, 4) != 0) t.push_back(CH_NEWLINE);
        end
        5, 6: t.push_back(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]);
        7: begin
          s = near_ops[$urandom_range(0, $size(near_ops) - 1)];
          for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        end
        8: t.push_back(8'($urandom_range(0, 255)));
        9: t.push_back("'");
        default: t.push_back(($urandom_range(0, 3) == 0) ? CH_NEWLINE : 8'h20);
      endcase
    end
    if (t.size() > 1 && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, t.size() - 1);
      t = t[0:n-1];
    end
    return t;
  endfunction

  // receiver: random stall phases, one long hold-off once traffic is going
  always @(posedge clk_i) begin
    if (!hold_done && inputs_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(8, 120);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      stall_span--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // handshake monitor: feed the predictor, check tokens, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_byte(text_byte_i, end_of_text_i);
      inputs_taken <= inputs_taken + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_token(token_kind_o, start_offset_o, token_length_o, last_of_run_o);
    end
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("source_text_tokenizer_tb failed");
      $finish;
    end
  end

  initial begin
    text_q_t     txt;
    int unsigned sent;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every single-byte punctuation mark, then the arrow, less-equal and greater-equal pairs
    send_text(bytes_of(";(){}[]+*/=!%&:,.-><=>="));
    // byte extremes, keyword, integer run straight into an identifier, empty
    // string, newline inside a string, comment, single quote, unclosed string
    txt = bytes_of("func 12ab\"\"\"\n\"#c\n'\"x");
    txt.push_front(8'hFF);
    txt.push_front(8'h00);
    send_text(txt);
    // texts ending on a pending minus, less and greater
    send_text(bytes_of("-"));
    send_text(bytes_of("a<"));
    send_text(bytes_of(">"));

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      txt = random_text();
      send_text(txt);
      sent += txt.size();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("source_text_tokenizer_tb passed");
    end else begin
      $display("source_text_tokenizer_tb failed");
    end
    $finish;
  end

endmodule
